@@ sv/integer_to_ascii_formatter_macros.svh @@
// Assertion helpers used by the formatter's serializer module.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITAF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/itaf_pkg.sv @@
package itaf_pkg;

  localparam int MAX_FIELD_WIDTH_DEF = 63;
  localparam int TEXT_LEN = 11;

  // Conversion modes; six and seven act like the bad conversion.
  localparam logic [2:0] MODE_SDEC  = 3'd0;
  localparam logic [2:0] MODE_UDEC  = 3'd1;
  localparam logic [2:0] MODE_HEXL  = 3'd2;
  localparam logic [2:0] MODE_HEXU  = 3'd3;
  localparam logic [2:0] MODE_PTR   = 3'd4;
  localparam logic [2:0] MODE_BAD   = 3'd5;
  localparam logic [2:0] MODE_RSV6  = 3'd6;
  localparam logic [2:0] MODE_RSV7  = 3'd7;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UD    = 8'h44;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [5:0]  min_width;
    logic        pad_before;
    logic        zero_fill;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_t;

  // One formatted item handed to the serializer.
  typedef struct packed {
    logic [TEXT_LEN-1:0][7:0] text;
    logic [3:0]               start;
    logic [3:0]               len;
    logic [5:0]               lead;
    logic [5:0]               total;
    logic [7:0]               pad_char;
  } load_t;

  // Eight double-dabble steps on {bcd[39:0], bin[31:0]}.
  function automatic logic [71:0] dabble8(input logic [71:0] w_in);
    logic [71:0] w;
    w = w_in;
    for (int s = 0; s < 8; s++) begin
      for (int d = 0; d < 10; d++) begin
        if (w[32+4*d +: 4] >= 4'd5) begin
          w[32+4*d +: 4] = w[32+4*d +: 4] + 4'd3;
        end
      end
      w = {w[70:0], 1'b0};
    end
    return w;
  endfunction

endpackage

@@ sv/itaf_serializer.sv @@
`include "integer_to_ascii_formatter_macros.svh"

module itaf_serializer (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  input  itaf_pkg::load_t load,
  output logic          take,
  output logic          text_valid,
  input  logic          text_stall,
  output itaf_pkg::out_t text_data
);

  itaf_pkg::load_t cur;
  logic            busy;
  logic [5:0]      pos;
  logic [5:0]      rel;
  logic [3:0]      idx;
  logic [6:0]      text_end;
  logic            in_lead;
  logic            in_text;
  logic            is_last;
  logic            beat;

  // Character selection for the current position.
  always_comb begin
    rel       = pos - cur.lead;
    idx       = cur.start + rel[3:0];
    text_end  = {1'b0, cur.lead} + {3'b0, cur.len};
    in_lead   = pos < cur.lead;
    in_text   = {1'b0, pos} < text_end;
    is_last   = pos == (cur.total - 6'd1);
    beat      = busy && !text_stall;
    take      = !busy || (beat && is_last);
    text_valid = busy;
    text_data.last = is_last;
    if (in_lead) begin
      text_data.character = cur.pad_char;
    end else if (in_text) begin
      text_data.character = cur.text[idx];
    end else begin
      text_data.character = itaf_pkg::CH_SPACE;
    end
  end

  // Run control: load a new item when idle or as the previous last beat leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (take) begin
      busy <= load_valid;
      pos  <= '0;
    end else if (beat) begin
      pos <= pos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      cur <= load;
    end
  end

  `ITAF_ASSERT_IMPL(a_pos_range, busy, pos < cur.total, "position beyond run")
  `ITAF_ASSERT_IMPL(a_idx_range, busy && !in_lead && in_text, idx <= 4'd10, "text index")
  `ITAF_ASSERT_NEXT(a_restart, beat && is_last, !busy || pos == 6'd0, "run not restarted")
  `ITAF_ASSERT_IMPL(a_len_nonzero, busy, cur.len != 4'd0 && cur.total >= 6'(cur.len), "bad run length")

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter.
// Input channel item_valid/item_stall/item_data carries one value with its
// mode, field width and padding flags. Output channel text_valid/text_stall/
// text_data returns the formatted text, one character per beat, with last set
// on the final character of each item.
// An accepted item passes an input register and four binary-to-BCD stages of
// eight shift steps each before it reaches the output serializer. The stage
// registers take a new item every cycle while free.
// The output serializer sends max(field width, text length) characters per
// item, at most 63, one per cycle while text_stall is low. The next item
// loads in the cycle the last character leaves, so runs follow without a gap.
// Reset (rst, synchronous) empties all stages and the serializer.
// While text_stall is high the current character holds; the stages fill up
// behind it and item_stall rises once every stage is occupied.
module integer_to_ascii_formatter #(
  parameter int MAX_FIELD_WIDTH = itaf_pkg::MAX_FIELD_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  itaf_pkg::in_t  item_data,
  output logic           text_valid,
  input  logic           text_stall,
  output itaf_pkg::out_t text_data
);

  localparam int NSTAGE = 5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [5:0]  width;
    logic        pad_before;
    logic        zero_fill;
    logic        neg;
  } ctl_t;

  ctl_t        ctl   [NSTAGE];
  logic [71:0] work  [NSTAGE];
  logic        vld   [NSTAGE];
  logic        adv   [NSTAGE+1];
  logic        take;
  ctl_t        ctl_next;
  logic [31:0] mag;
  itaf_pkg::load_t load;

  // Input decode: clamp width and take the magnitude of negative values.
  always_comb begin
    ctl_next.mode       = item_data.mode;
    ctl_next.value      = item_data.value;
    ctl_next.width      = (item_data.min_width > 6'(MAX_FIELD_WIDTH))
                          ? 6'(MAX_FIELD_WIDTH) : item_data.min_width;
    ctl_next.pad_before = item_data.pad_before;
    ctl_next.zero_fill  = item_data.zero_fill;
    ctl_next.neg        = (item_data.mode == itaf_pkg::MODE_SDEC) && item_data.value[31];
    mag = ctl_next.neg ? (~item_data.value + 32'd1) : item_data.value;
  end

  // Flow control: a stage moves when it is empty or its successor moves.
  assign adv[NSTAGE] = take;
  for (genvar k = 0; k < NSTAGE; k++) begin : g_flow
    assign adv[k] = !vld[k] || adv[k+1];
  end
  assign item_stall = !adv[0];

  // Stage registers: input register, then four conversion stages.
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= (k == 0) ? item_valid : vld[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        if (k == 0) begin
          ctl[k]  <= ctl_next;
          work[k] <= {40'd0, mag};
        end else begin
          ctl[k]  <= ctl[(k == 0) ? 0 : k-1];
          work[k] <= itaf_pkg::dabble8(work[(k == 0) ? 0 : k-1]);
        end
      end
    end
  end

  // Text layout from the converted digits.
  always_comb begin
    ctl_t       c;
    logic [3:0] fst;
    logic [3:0] hfst;
    logic [3:0] dig;
    logic [3:0] nib;
    logic [5:0] w;
    logic       zp;
    c    = ctl[NSTAGE-1];
    fst  = 4'd10;
    hfst = 4'd10;
    dig  = 4'd0;
    nib  = 4'd0;
    load.text = '0;
    load.start = 4'd0;
    unique case (c.mode)
      itaf_pkg::MODE_SDEC, itaf_pkg::MODE_UDEC: begin
        for (int j = 9; j >= 0; j--) begin
          if (work[NSTAGE-1][32+4*(9-j) +: 4] != 4'd0) begin
            fst = 4'(j + 1);
          end
        end
        for (int i = 0; i < 11; i++) begin
          if (i == 0) begin
            load.text[i] = itaf_pkg::CH_MINUS;
          end else begin
            dig = work[NSTAGE-1][32+4*(10-i) +: 4];
            load.text[i] = (c.neg && 4'(i) == fst - 4'd1)
                           ? itaf_pkg::CH_MINUS : itaf_pkg::CH_ZERO + {4'd0, dig};
          end
        end
        load.start = c.neg ? fst - 4'd1 : fst;
      end
      itaf_pkg::MODE_HEXL, itaf_pkg::MODE_HEXU, itaf_pkg::MODE_PTR: begin
        for (int j = 7; j >= 0; j--) begin
          if (c.value[28-4*j +: 4] != 4'd0) begin
            hfst = 4'(j + 3);
          end
        end
        for (int j = 0; j < 8; j++) begin
          nib = c.value[28-4*j +: 4];
          if (nib < 4'd10) begin
            load.text[3+j] = itaf_pkg::CH_ZERO + {4'd0, nib};
          end else if (c.mode == itaf_pkg::MODE_HEXL) begin
            load.text[3+j] = itaf_pkg::CH_LA + {4'd0, nib - 4'd10};
          end else begin
            load.text[3+j] = itaf_pkg::CH_UA + {4'd0, nib - 4'd10};
          end
        end
        load.start = (c.mode == itaf_pkg::MODE_PTR) ? 4'd3 : hfst;
      end
      default: begin
        load.text[6]  = itaf_pkg::CH_PCT;
        load.text[7]  = itaf_pkg::CH_UB;
        load.text[8]  = itaf_pkg::CH_UA;
        load.text[9]  = itaf_pkg::CH_UD;
        load.text[10] = itaf_pkg::CH_PCT;
        load.start = 4'd6;
      end
    endcase
    load.len = 4'd11 - load.start;
    w  = (c.mode == itaf_pkg::MODE_PTR) ? 6'd8 : c.width;
    zp = (c.mode == itaf_pkg::MODE_PTR) || c.zero_fill;
    load.total = (w > {2'b0, load.len}) ? w : {2'b0, load.len};
    load.lead  = ((c.pad_before || zp) && w > {2'b0, load.len})
                 ? w - {2'b0, load.len} : 6'd0;
    load.pad_char = zp ? itaf_pkg::CH_ZERO : itaf_pkg::CH_SPACE;
  end

  itaf_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (vld[NSTAGE-1]),
    .load       (load),
    .take       (take),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_data  (text_data)
  );

endmodule

@@ test/tb.sv @@
module tb;

  localparam int MAX_W = itaf_pkg::MAX_FIELD_WIDTH_DEF;

  // Scoreboard of expected characters, filled from accepted items.
  class char_scoreboard;
    itaf_pkg::out_t pending[$];
    int   errors;
    int   items;
    int   chars;

    // Format one accepted item into its expected character beats.
    function void note_item(itaf_pkg::in_t it);
      logic [7:0] txt[$];
      logic [31:0] mag;
      logic [31:0] dv;
      logic [31:0] d;
      logic [31:0] v;
      logic [3:0] nib;
      logic [7:0] c;
      logic [7:0] padc;
      bit started;
      bit zp;
      int w;
      int lead;
      int trail;
      int n;
      itaf_pkg::out_t o;
      w = it.min_width;
      if (w > MAX_W) begin
        w = MAX_W;
      end
      zp = it.zero_fill;
      case (it.mode)
        itaf_pkg::MODE_SDEC, itaf_pkg::MODE_UDEC: begin
          mag = it.value;
          if (it.mode == itaf_pkg::MODE_SDEC && it.value[31]) begin
            txt.push_back(itaf_pkg::CH_MINUS);
            mag = ~it.value + 32'd1;
          end
          if (mag == 0) begin
            txt.push_back(itaf_pkg::CH_ZERO);
          end else begin
            dv = 32'd1000000000;
            started = 0;
            while (dv > 0) begin
              d = mag / dv;
              mag = mag - d * dv;
              dv = dv / 10;
              if (d != 0 || started) begin
                started = 1;
                txt.push_back(itaf_pkg::CH_ZERO + d[7:0]);
              end
            end
          end
        end
        itaf_pkg::MODE_HEXL, itaf_pkg::MODE_HEXU, itaf_pkg::MODE_PTR: begin
          v = it.value;
          started = (it.mode == itaf_pkg::MODE_PTR);
          for (int i = 0; i < 8; i++) begin
            nib = v[31:28];
            v = v << 4;
            if (nib > 9) begin
              c = ((it.mode == itaf_pkg::MODE_HEXL) ? itaf_pkg::CH_LA : itaf_pkg::CH_UA)
                  + nib - 8'd10;
            end else begin
              c = itaf_pkg::CH_ZERO + nib;
            end
            if (nib != 0 || started || i == 7) begin
              started = 1;
              txt.push_back(c);
            end
          end
          if (it.mode == itaf_pkg::MODE_PTR) begin
            w = 8;
            zp = 1;
          end
        end
        default: begin
          txt.push_back(itaf_pkg::CH_PCT);
          txt.push_back(itaf_pkg::CH_UB);
          txt.push_back(itaf_pkg::CH_UA);
          txt.push_back(itaf_pkg::CH_UD);
          txt.push_back(itaf_pkg::CH_PCT);
        end
      endcase
      n = txt.size();
      lead = 0;
      trail = 0;
      if (it.pad_before || zp) begin
        lead = (w > n) ? w - n : 0;
      end else begin
        trail = (w > n) ? w - n : 0;
      end
      padc = zp ? itaf_pkg::CH_ZERO : itaf_pkg::CH_SPACE;
      for (int i = 0; i < lead; i++) begin
        txt.push_front(padc);
      end
      for (int i = 0; i < trail; i++) begin
        txt.push_back(itaf_pkg::CH_SPACE);
      end
      foreach (txt[i]) begin
        o.character = txt[i];
        o.last = (i == txt.size() - 1);
        pending.push_back(o);
      end
      items++;
    endfunction

    // Compare one output beat with the oldest expected character.
    function void check_char(itaf_pkg::out_t got);
      itaf_pkg::out_t exp_c;
      chars++;
      if (pending.size() == 0) begin
        $error("unexpected character beat %h", got.character);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.character !== exp_c.character) begin
        $error("character: expected %h, actual %h", exp_c.character, got.character);
        errors++;
      end
      if (got.last !== exp_c.last) begin
        $error("last: expected %b, actual %b", exp_c.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  itaf_pkg::in_t  item_data = '0;
  logic text_valid;
  logic text_stall = 0;
  itaf_pkg::out_t text_data;

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_recv = 0;
  char_scoreboard sb;

  integer_to_ascii_formatter uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item_data(item_data),
    .text_valid(text_valid), .text_stall(text_stall), .text_data(text_data)
  );

  always #2 clk = ~clk;

  // Offer one item and wait until the block takes the beat. Valid stays high
  // after the beat so that the next item can follow without a gap.
  task automatic send_item(itaf_pkg::in_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item_data <= it;
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
    sb.note_item(it);
  endtask

  // Build one directed item and send it.
  task automatic send_mk(logic [2:0] m, logic [31:0] v, logic [5:0] w,
                         logic pb, logic z);
    itaf_pkg::in_t it;
    it.mode = m;
    it.value = v;
    it.min_width = w;
    it.pad_before = pb;
    it.zero_fill = z;
    send_item(it);
  endtask

  // Random item: small widths mostly, value classes weighted toward edges.
  function automatic itaf_pkg::in_t rand_item();
    itaf_pkg::in_t it;
    int r;
    it.mode = 3'($urandom_range(7));
    r = $urandom_range(9);
    case (r)
      0: it.value = 32'd0;
      1: it.value = 32'hFFFFFFFF;
      2: it.value = 32'h80000000;
      3: it.value = 32'($urandom_range(20));
      4: it.value = 32'hFFFFFFFF - 32'($urandom_range(20));
      5: it.value = $urandom >> $urandom_range(31);
      default: it.value = $urandom;
    endcase
    it.min_width = ($urandom_range(19) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(14));
    it.pad_before = 1'($urandom_range(1));
    it.zero_fill = 1'($urandom_range(1));
    return it;
  endfunction

  // Receiver: random stall, plus a long hold-off on request.
  always @(posedge clk) begin
    if (text_valid && !text_stall && !rst) begin
      sb.check_char(text_data);
    end
    if (hold_recv) begin
      text_stall <= 1;
    end else begin
      text_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end
  end

  // Drain the expected characters, then allow the pipeline to settle.
  task automatic drain();
    item_valid <= 0;
    while (sb.pending.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, every mode and the special cases.
    send_mk(itaf_pkg::MODE_SDEC, 32'h80000000, 6'd0, 0, 0);
    send_mk(itaf_pkg::MODE_SDEC, 32'hFFFFFFFB, 6'd5, 0, 1);
    send_mk(itaf_pkg::MODE_SDEC, 32'hFFFFFFFB, 6'd5, 1, 0);
    send_mk(itaf_pkg::MODE_SDEC, 32'd0, 6'd0, 0, 0);
    send_mk(itaf_pkg::MODE_SDEC, 32'h7FFFFFFF, 6'd63, 0, 0);
    send_mk(itaf_pkg::MODE_UDEC, 32'hFFFFFFFF, 6'd63, 1, 1);
    send_mk(itaf_pkg::MODE_UDEC, 32'd0, 6'd3, 1, 0);
    send_mk(itaf_pkg::MODE_HEXL, 32'hDEADBEEF, 6'd10, 0, 1);
    send_mk(itaf_pkg::MODE_HEXU, 32'h00ABCDEF, 6'd4, 0, 0);
    send_mk(itaf_pkg::MODE_HEXL, 32'd0, 6'd2, 1, 0);
    send_mk(itaf_pkg::MODE_PTR, 32'h0000001F, 6'd63, 0, 0);
    send_mk(itaf_pkg::MODE_PTR, 32'hFFFFFFFF, 6'd0, 1, 0);
    send_mk(itaf_pkg::MODE_BAD, 32'd1, 6'd8, 1, 0);
    send_mk(itaf_pkg::MODE_RSV6, 32'd2, 6'd8, 0, 0);
    send_mk(itaf_pkg::MODE_RSV7, 32'd3, 6'd2, 0, 1);
    send_mk(itaf_pkg::MODE_UDEC, 32'd1234567890, 6'd1, 1, 1);
    drain();

    // Long receiver hold-off while items keep arriving.
    fork
      begin
        hold_recv = 1;
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int i = 0; i < 12; i++) begin
          send_item(rand_item());
        end
      end
    join
    drain();

    // Three idle profiles over the random part.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 73 : 0;
      recv_idle = (ph == 0) ? 73 : (ph == 1) ? 12 : 0;
      for (int i = 0; i < 155; i++) begin
        send_item(rand_item());
      end
      drain();
    end

    $display("Covered %0d items and %0d characters across all modes and pad options.",
             sb.items, sb.chars);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("integer_to_ascii_formatter regression: pass");
    end else begin
      $display("integer_to_ascii_formatter regression: fail");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #4000000;
    $display("integer_to_ascii_formatter regression: fail");
    $finish;
  end
endmodule
